### src/pxk_pkg.sv
package pxk_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int K_MAX     = 64;
  localparam int DATA_BITS = 32;

  localparam int COL_W  = $clog2(MAX_COLS);      // column index width
  localparam int CCNT_W = $clog2(MAX_COLS + 1);  // column_count register width
  localparam int CNT_W  = $clog2(K_MAX + 1);     // rank / fill count width
  localparam int TOP_AW = $clog2(K_MAX);         // sorted store address width

  localparam int CFG_AW = 1;
  localparam int CFG_DW = (CCNT_W > CNT_W) ? CCNT_W : CNT_W;

  localparam logic [CFG_AW-1:0] CFG_COLUMN_COUNT = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_RANK_K       = 1'b1;

  // commands from the line and result states to the sorted store
  typedef struct packed {
    logic             insert;
    logic             clear;
    logic [CNT_W-1:0] rank;
  } rank_ctl_t;

  typedef struct packed {
    logic busy;
    logic found;
  } rank_sts_t;

endpackage

### src/prefix_xor_kth_largest_core.sv
// prefix xor k-th largest core
//
// input stream (s_*): matrix elements in row-major order, one item each,
// s_tlast on the final element of a matrix. the row length and the rank
// come from the configuration port (cfg_we / cfg_addr / cfg_data). the user
// must write it only while the core is idle; the core does not enforce it.
// each element forms its 2d prefix xor from the row running xor and the
// previous row's prefix held in a 1024-entry line ram (read, then written
// back the next cycle). the prefix is then inserted into a 64-entry sorted
// ram by a sweep that reads one entry a cycle and writes back the bubbled
// value, over every filled entry; no new element is taken until the sweep
// over the sorted ram ends.
// output stream (m_*): one item per matrix, issued through the result state
// once the sweep of the last element ends; m_tuser is the found flag.
// the output register holds a result while the receiver stalls; new input
// items keep flowing until the next matrix's result, which waits for it to
// drain in the result state with input held. reset (synchronous, active high)
// returns to the start of a matrix with row length 1 and rank 1; no clearing pass is needed.

module prefix_xor_kth_largest_core
  import pxk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DATA_BITS-1:0] s_tdata,   // [31:0] element_value
  input  logic                 s_tlast,   // last_element
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_BITS-1:0] m_tdata,   // [31:0] kth_value
  output logic                 m_tuser,   // [0] found
  input  logic                 cfg_we,
  input  logic [CFG_AW-1:0]    cfg_addr,
  input  logic [CFG_DW-1:0]    cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LINE   = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t               state;
  logic [CCNT_W-1:0]    column_count;
  logic [CNT_W-1:0]     rank_k;
  logic [COL_W-1:0]     column_index;
  logic [DATA_BITS-1:0] row_running_xor;
  logic                 in_first_row;
  logic [DATA_BITS-1:0] elem;
  logic                 last_flag;

  logic [CCNT_W-1:0]    cols_eff;
  logic [CNT_W-1:0]     rank_eff;
  logic [CCNT_W-1:0]    col_inc;
  logic [DATA_BITS-1:0] row_xor_new;
  logic [DATA_BITS-1:0] line_rdata;
  logic [DATA_BITS-1:0] prefix;
  logic                 out_free;
  logic                 in_take;

  rank_ctl_t            rank_ctl;
  rank_sts_t            rank_sts;
  logic [DATA_BITS-1:0] kth_value;

  assign s_tready = (state == ST_IDLE);
  assign in_take  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // out-of-range register values act as the nearest legal value
  always_comb begin
    if (column_count == '0) begin
      cols_eff = CCNT_W'(1);
    end else if (column_count > CCNT_W'(MAX_COLS)) begin
      cols_eff = CCNT_W'(MAX_COLS);
    end else begin
      cols_eff = column_count;
    end
    if (rank_k == '0) begin
      rank_eff = CNT_W'(1);
    end else if (rank_k > CNT_W'(K_MAX)) begin
      rank_eff = CNT_W'(K_MAX);
    end else begin
      rank_eff = rank_k;
    end
  end

  // prefix = xor of this row so far and the same column one row up
  assign col_inc     = {1'b0, column_index} + CCNT_W'(1);
  assign row_xor_new = row_running_xor ^ elem;
  assign prefix      = (in_first_row ? '0 : line_rdata) ^ row_xor_new;

  // line ram: read issued while idle, written back in the line state
  pxk_ram #(
    .DEPTH (MAX_COLS),
    .WIDTH (DATA_BITS)
  ) u_line_mem (
    .clk   (clk),
    .we    (state == ST_LINE),
    .waddr (column_index),
    .wdata (prefix),
    .raddr (column_index),
    .rdata (line_rdata)
  );

  assign rank_ctl.insert = (state == ST_LINE);
  assign rank_ctl.clear  = (state == ST_RESULT) && out_free;
  assign rank_ctl.rank   = rank_eff;

  pxk_rank_store u_rank_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rank_ctl),
    .ins_value (prefix),
    .sts       (rank_sts),
    .kth_value (kth_value)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= CCNT_W'(1);
      rank_k       <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_COLUMN_COUNT: column_count <= cfg_data[CCNT_W-1:0];
        CFG_RANK_K:       rank_k       <= cfg_data[CNT_W-1:0];
        default:          ;
      endcase
    end
  end

  // item capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      elem      <= s_tdata;
      last_flag <= s_tlast;
    end
  end

  // sequencer and row tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      column_index    <= '0;
      row_running_xor <= '0;
      in_first_row    <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= ST_LINE;
          end
        end
        ST_LINE: begin
          // a row, also a shortened one, ends once the next index reaches its length
          if (col_inc >= cols_eff) begin
            column_index    <= '0;
            row_running_xor <= '0;
            in_first_row    <= 1'b0;
          end else begin
            column_index    <= col_inc[COL_W-1:0];
            row_running_xor <= row_xor_new;
          end
          state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          // once the sweep is done the store reads the reported entry
          if (!rank_sts.busy) begin
            state <= last_flag ? ST_RESULT : ST_IDLE;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            column_index    <= '0;
            row_running_xor <= '0;
            in_first_row    <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output valid: loaded from the result state, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_RESULT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESULT) && out_free) begin
      m_tdata <= kth_value;
      m_tuser <= rank_sts.found;
    end
  end

  // the sorted store never sweeps while a new item can be taken
  a_idle_store_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !rank_sts.busy)
    else $error("sorted store busy while idle");

  // an accepted item always goes to the line stage next
  a_take_to_line: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_LINE))
    else $error("accepted item skipped the line stage");

  // a result only appears out of the result state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_RESULT))
    else $error("output raised outside the result state");

endmodule

### src/pxk_ram.sv
module pxk_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/pxk_rank_store.sv
module pxk_rank_store
  import pxk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  rank_ctl_t            ctl,
  input  logic [DATA_BITS-1:0] ins_value,
  output rank_sts_t            sts,
  output logic [DATA_BITS-1:0] kth_value
);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     idx_inc;
  logic [CNT_W-1:0]     sel;
  logic [DATA_BITS-1:0] carry;
  logic                 sweeping;
  logic                 found;
  logic                 at_end;
  logic                 swap;
  logic                 we;
  logic [TOP_AW-1:0]    raddr;
  logic [DATA_BITS-1:0] rdata;

  // entries stay in descending order; a sweep bubbles the new value down
  always_comb begin
    idx_inc = idx + CNT_W'(1);
    found   = (count >= ctl.rank);
    sel     = found ? (ctl.rank - CNT_W'(1)) : (count - CNT_W'(1));
    at_end  = (idx == count);
    swap    = !at_end && (rdata < carry);
    we      = sweeping && (swap || (at_end && (count < CNT_W'(K_MAX))));
    if (ctl.insert) begin
      raddr = '0;
    end else if (sweeping) begin
      raddr = idx_inc[TOP_AW-1:0];
    end else begin
      raddr = sel[TOP_AW-1:0];
    end
  end

  pxk_ram #(
    .DEPTH (K_MAX),
    .WIDTH (DATA_BITS)
  ) u_top_mem (
    .clk   (clk),
    .we    (we),
    .waddr (idx[TOP_AW-1:0]),
    .wdata (carry),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping <= 1'b0;
      count    <= '0;
    end else begin
      if (ctl.clear) begin
        count <= '0;
      end
      if (ctl.insert) begin
        sweeping <= 1'b1;
        idx      <= '0;
        carry    <= ins_value;
      end else if (sweeping) begin
        if (at_end) begin
          sweeping <= 1'b0;
          if (count < CNT_W'(K_MAX)) begin
            count <= count + CNT_W'(1);
          end
        end else begin
          if (swap) begin
            carry <= rdata;
          end
          idx <= idx_inc;
        end
      end
    end
  end

  assign sts.busy  = sweeping;
  assign sts.found = found;
  assign kth_value = rdata;

endmodule
